// File: rtl/hsvmx_pkg.sv
// shared constants and types of the hsv mask extreme point tracker
package hsvmx_pkg;

    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;
    localparam int LX_W       = 12;
    localparam int PT_W       = 11;
    localparam int TY_W       = 12;
    localparam int SPAN_W     = 12;
    localparam int RATIO_W    = 10;
    localparam int BIT_W      = 4;
    localparam int SCALE_W    = 12;
    localparam int RATIO_SCALE = 2112;
    localparam int RATIO_MAX   = 844;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HUE_LOW,
        REG_HUE_HIGH,
        REG_SAT_LOW,
        REG_SAT_HIGH,
        REG_VAL_LOW,
        REG_VAL_HIGH,
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT
    } cfg_index_t;

endpackage

// File: rtl/hsv_mask_extreme_point_tracker.sv
// top level of the hsv mask extreme point tracker
// usage:
//   pixels enter in raster order on hue/saturation/brightness; a request is
//   taken at a clock edge with push high and full low, one per cycle.
//   after the last pixel of a frame one result appears on the result ports;
//   it is shown while empty is low and taken at an edge with pop high.
//   configuration is written through cfg_write/cfg_index/cfg_data while idle;
//   frame size is used from the next pixel on.
// throughput and steps:
//   pixels: one per cycle while full is low. per frame the back part works
//   after the last pixel through abs differences, squares, sums, then ten
//   steps of a multiply-compare per ratio bit (both ratios side by side),
//   and then loads the result register. a two-entry queue of frame records
//   decouples the parts.
// stalls:
//   a held result blocks the back part; once the queue is full, full rises
//   and pixels are held off until a record is drained.
// reset:
//   position returns to column 0, row 0; bounds to full range; size to 640x480.
module hsv_mask_extreme_point_tracker
    import hsvmx_pkg::*;
#(
    parameter int MAX_DIM = 2048
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [CH_W-1:0]       hue,
    input  logic [CH_W-1:0]       saturation,
    input  logic [CH_W-1:0]       brightness,
    input  logic                  pop,
    output logic                  empty,
    output logic [LX_W-1:0]       left_x,
    output logic [PT_W-1:0]       left_y,
    output logic [PT_W-1:0]       right_x,
    output logic [PT_W-1:0]       right_y,
    output logic [PT_W-1:0]       top_x,
    output logic [TY_W-1:0]       top_y,
    output logic [RATIO_W-1:0]    left_ratio,
    output logic [RATIO_W-1:0]    right_ratio,
    output logic [SPAN_W-1:0]     span
);

    localparam int REC_W = 2 * ($clog2(MAX_DIM) + 1) + 4 * $clog2(MAX_DIM);

    logic             accept;
    logic             rec_push;
    logic [REC_W-1:0] rec_data;
    logic [REC_W-1:0] q_data;
    logic             q_pop;
    logic             q_empty;
    logic             q_full;

    assign full   = q_full;
    assign accept = push && !q_full;

    hsvmx_front #(.MAX_DIM(MAX_DIM)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .rec_push   (rec_push),
        .rec_data   (rec_data)
    );

    hsvmx_fifo #(.W(REC_W)) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (rec_push),
        .wdata (rec_data),
        .rd    (q_pop),
        .rdata (q_data),
        .full  (q_full),
        .empty (q_empty)
    );

    hsvmx_back #(.MAX_DIM(MAX_DIM)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .left_x      (left_x),
        .left_y      (left_y),
        .right_x     (right_x),
        .right_y     (right_y),
        .top_x       (top_x),
        .top_y       (top_y),
        .left_ratio  (left_ratio),
        .right_ratio (right_ratio),
        .span        (span)
    );

endmodule

// File: rtl/hsvmx_fifo.sv
// two-entry queue of frame records between front and back
module hsvmx_fifo
    import hsvmx_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wdata,
    input  logic         rd,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);

    logic [W-1:0] mem_reg [2];
    logic         wptr_reg;
    logic         rptr_reg;
    logic [1:0]   count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (wr && !full)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd && !empty)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if ((wr && !full) && !(rd && !empty))
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!(wr && !full) && (rd && !empty))
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/hsvmx_front.sv
// front part: configuration, pixel mask, raster position and extreme point tracking
module hsvmx_front
    import hsvmx_pkg::*;
#(
    parameter int MAX_DIM = 2048
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic [CH_W-1:0]       hue,
    input  logic [CH_W-1:0]       saturation,
    input  logic [CH_W-1:0]       brightness,
    output logic                  rec_push,
    output logic [2*($clog2(MAX_DIM)+1)+4*$clog2(MAX_DIM)-1:0] rec_data
);

    localparam int DIM_W = $clog2(MAX_DIM) + 1;
    localparam int CNT_W = $clog2(MAX_DIM);

    logic [CH_W-1:0]       hue_low_reg, hue_high_reg;
    logic [CH_W-1:0]       sat_low_reg, sat_high_reg;
    logic [CH_W-1:0]       val_low_reg, val_high_reg;
    logic [CFG_DATA_W-1:0] width_reg, height_reg;

    logic [CNT_W-1:0] col_reg, row_reg, col_next, row_next;
    logic [DIM_W-1:0] lx_reg, lx_next, ty_reg, ty_next;
    logic [CNT_W-1:0] ly_reg, ly_next, rx_reg, rx_next, ry_reg, ry_next, tx_reg, tx_next;
    logic [DIM_W-1:0] w_clamp, h_clamp;
    logic             start, marked, row_end, frame_end;
    logic [DIM_W-1:0] lx_cur, ty_cur;
    logic [CNT_W-1:0] ly_cur, rx_cur, ry_cur, tx_cur;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    assign w_clamp = clamp_dim(width_reg);
    assign h_clamp = clamp_dim(height_reg);
    assign start   = (col_reg == '0) && (row_reg == '0);

    assign marked = (hue >= hue_low_reg) && (hue <= hue_high_reg) &&
                    (saturation >= sat_low_reg) && (saturation <= sat_high_reg) &&
                    (brightness >= val_low_reg) && (brightness <= val_high_reg);

    always_comb
    begin
        lx_cur = start ? w_clamp : lx_reg;
        ly_cur = start ? '0 : ly_reg;
        rx_cur = start ? '0 : rx_reg;
        ry_cur = start ? '0 : ry_reg;
        tx_cur = start ? '0 : tx_reg;
        ty_cur = start ? h_clamp : ty_reg;

        lx_next = lx_cur;
        ly_next = ly_cur;
        rx_next = rx_cur;
        ry_next = ry_cur;
        tx_next = tx_cur;
        ty_next = ty_cur;
        if (marked)
        begin
            if (DIM_W'(row_reg) < ty_cur)
            begin
                tx_next = col_reg;
                ty_next = DIM_W'(row_reg);
            end
            if (DIM_W'(col_reg) < lx_cur)
            begin
                lx_next = DIM_W'(col_reg);
                ly_next = row_reg;
            end
            if (col_reg > rx_cur)
            begin
                rx_next = col_reg;
                ry_next = row_reg;
            end
        end

        row_end   = (DIM_W'(col_reg) + DIM_W'(1)) >= w_clamp;
        frame_end = row_end && ((DIM_W'(row_reg) + DIM_W'(1)) >= h_clamp);
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + CNT_W'(1);
        end
        else
        begin
            col_next = col_reg + CNT_W'(1);
            row_next = row_reg;
        end
    end

    assign rec_push = accept && frame_end;
    assign rec_data = {lx_next, ly_next, rx_next, ry_next, tx_next, ty_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_reg  <= '0;
            hue_high_reg <= '1;
            sat_low_reg  <= '0;
            sat_high_reg <= '1;
            val_low_reg  <= '0;
            val_high_reg <= '1;
            width_reg    <= CFG_DATA_W'(640);
            height_reg   <= CFG_DATA_W'(480);
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index_t'(cfg_index))
                    REG_HUE_LOW:      hue_low_reg  <= cfg_data[CH_W-1:0];
                    REG_HUE_HIGH:     hue_high_reg <= cfg_data[CH_W-1:0];
                    REG_SAT_LOW:      sat_low_reg  <= cfg_data[CH_W-1:0];
                    REG_SAT_HIGH:     sat_high_reg <= cfg_data[CH_W-1:0];
                    REG_VAL_LOW:      val_low_reg  <= cfg_data[CH_W-1:0];
                    REG_VAL_HIGH:     val_high_reg <= cfg_data[CH_W-1:0];
                    REG_FRAME_WIDTH:  width_reg    <= cfg_data;
                    REG_FRAME_HEIGHT: height_reg   <= cfg_data;
                    default:          ;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lx_reg <= lx_next;
            ly_reg <= ly_next;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            tx_reg <= tx_next;
            ty_reg <= ty_next;
        end
    end

endmodule

// File: rtl/hsvmx_back.sv
// back part: distance, bit-serial ratio search and result register
module hsvmx_back
    import hsvmx_pkg::*;
#(
    parameter int MAX_DIM = 2048
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  logic [2*($clog2(MAX_DIM)+1)+4*$clog2(MAX_DIM)-1:0] q_data,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output logic [LX_W-1:0]     left_x,
    output logic [PT_W-1:0]     left_y,
    output logic [PT_W-1:0]     right_x,
    output logic [PT_W-1:0]     right_y,
    output logic [PT_W-1:0]     top_x,
    output logic [TY_W-1:0]     top_y,
    output logic [RATIO_W-1:0]  left_ratio,
    output logic [RATIO_W-1:0]  right_ratio,
    output logic [SPAN_W-1:0]   span
);

    localparam int DIM_W  = $clog2(MAX_DIM) + 1;
    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int D2_W   = 2 * DIM_W + 1;
    localparam int NL_W   = DIM_W + SCALE_W;
    localparam int N_W    = 2 * NL_W;
    localparam int SQ_W   = 2 * RATIO_W;
    localparam int PROD_W = SQ_W + D2_W;
    localparam int CMP_W  = (PROD_W > N_W) ? PROD_W : N_W;

    typedef enum logic [2:0] {S_IDLE, S_SQ, S_SUM, S_MUL1, S_MUL2, S_DONE} state_t;

    state_t             state_reg;
    logic               out_valid_reg;
    logic [DIM_W-1:0]   lx_reg, ty_reg;
    logic [CNT_W-1:0]   ly_reg, rx_reg, ry_reg, tx_reg;
    logic [DIM_W-1:0]   dx_reg, dy_reg, dl_reg, dr_reg;
    logic [2*DIM_W-1:0] dx2_reg, dy2_reg;
    logic [NL_W-1:0]    nl_reg, nr_reg;
    logic [D2_W-1:0]    d2_reg;
    logic [N_W-1:0]     nl2_reg, nr2_reg;
    logic [SQ_W-1:0]    sql_reg, sqr_reg;
    logic [RATIO_W-1:0] rl_reg, rr_reg;
    logic [BIT_W-1:0]   bit_reg;

    logic [DIM_W-1:0]   q_lx, q_ty;
    logic [CNT_W-1:0]   q_ly, q_rx, q_ry, q_tx;
    logic [DIM_W-1:0]   ly_e, rx_e, ry_e;
    logic [RATIO_W-1:0] cand_l, cand_r, sat_l, sat_r;
    logic [CMP_W-1:0]   prod_l, prod_r;

    assign {q_lx, q_ly, q_rx, q_ry, q_tx, q_ty} = q_data;
    assign ly_e = DIM_W'(q_ly);
    assign rx_e = DIM_W'(q_rx);
    assign ry_e = DIM_W'(q_ry);

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    assign cand_l = rl_reg | (RATIO_W'(1) << bit_reg);
    assign cand_r = rr_reg | (RATIO_W'(1) << bit_reg);
    assign prod_l = CMP_W'(sql_reg) * CMP_W'(d2_reg);
    assign prod_r = CMP_W'(sqr_reg) * CMP_W'(d2_reg);
    assign sat_l  = (rl_reg >= RATIO_W'(RATIO_MAX)) ? RATIO_W'(RATIO_MAX) : rl_reg;
    assign sat_r  = (rr_reg >= RATIO_W'(RATIO_MAX)) ? RATIO_W'(RATIO_MAX) : rr_reg;
    assign empty  = !out_valid_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                lx_reg <= q_lx;
                ly_reg <= q_ly;
                rx_reg <= q_rx;
                ry_reg <= q_ry;
                tx_reg <= q_tx;
                ty_reg <= q_ty;
                dx_reg <= (q_lx > rx_e) ? q_lx - rx_e : rx_e - q_lx;
                dy_reg <= (ly_e > ry_e) ? ly_e - ry_e : ry_e - ly_e;
                dl_reg <= (q_ty > ly_e) ? q_ty - ly_e : ly_e - q_ty;
                dr_reg <= (q_ty > ry_e) ? q_ty - ry_e : ry_e - q_ty;
            end
            S_SQ:
            begin
                dx2_reg <= (2*DIM_W)'(dx_reg) * (2*DIM_W)'(dx_reg);
                dy2_reg <= (2*DIM_W)'(dy_reg) * (2*DIM_W)'(dy_reg);
                nl_reg  <= NL_W'(dl_reg) * NL_W'(RATIO_SCALE);
                nr_reg  <= NL_W'(dr_reg) * NL_W'(RATIO_SCALE);
            end
            S_SUM:
            begin
                d2_reg  <= D2_W'(dx2_reg) + D2_W'(dy2_reg);
                nl2_reg <= N_W'(nl_reg) * N_W'(nl_reg);
                nr2_reg <= N_W'(nr_reg) * N_W'(nr_reg);
            end
            S_MUL1:
            begin
                sql_reg <= SQ_W'(cand_l) * SQ_W'(cand_l);
                sqr_reg <= SQ_W'(cand_r) * SQ_W'(cand_r);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rl_reg        <= '0;
            rr_reg        <= '0;
            bit_reg       <= '0;
            left_x        <= '0;
            left_y        <= '0;
            right_x       <= '0;
            right_y       <= '0;
            top_x         <= '0;
            top_y         <= '0;
            left_ratio    <= '0;
            right_ratio   <= '0;
            span          <= '0;
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    rl_reg    <= '0;
                    rr_reg    <= '0;
                    bit_reg   <= BIT_W'(RATIO_W - 1);
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    if (prod_l <= CMP_W'(nl2_reg))
                    begin
                        rl_reg <= cand_l;
                    end
                    if (prod_r <= CMP_W'(nr2_reg))
                    begin
                        rr_reg <= cand_r;
                    end
                    if (bit_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        bit_reg   <= bit_reg - BIT_W'(1);
                        state_reg <= S_MUL1;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        left_x        <= LX_W'(lx_reg);
                        left_y        <= PT_W'(ly_reg);
                        right_x       <= PT_W'(rx_reg);
                        right_y       <= PT_W'(ry_reg);
                        top_x         <= PT_W'(tx_reg);
                        top_y         <= TY_W'(ty_reg);
                        left_ratio    <= sat_l;
                        right_ratio   <= sat_r;
                        span          <= SPAN_W'(rx_reg) - SPAN_W'(lx_reg);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_search_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL2 && bit_reg == '0) |=> (state_reg == S_DONE))
        else $error("ratio search did not finish after the last bit");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_valid_reg) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished request not moved to result register");

    a_ratio_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (left_ratio <= RATIO_W'(RATIO_MAX) &&
                           right_ratio <= RATIO_W'(RATIO_MAX)))
        else $error("ratio above saturation limit");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == S_SQ))
        else $error("queue popped outside idle");

endmodule
